// File: rtl/erm_pkg.sv
// Shared constants and saturation helpers for the Euler rotation matrix pipeline.
package erm_pkg;

    // Angle constants, Q12 radians
    localparam logic signed [16:0] PI_Q12      = 17'sd12868;
    localparam logic signed [16:0] TWO_PI_Q12  = 17'sd25736;
    localparam logic signed [16:0] HALF_PI_Q12 = 17'sd6434;

    // Quintic sine coefficients, Q20 (kept signed for signed products)
    localparam logic signed [21:0] C1_Q20 = 22'sd1035848;
    localparam logic signed [18:0] C3_Q20 = 19'sd162813;
    localparam logic signed [13:0] C5_Q20 = 14'sd5917;

    // Output range, Q1.14 in 16 bits
    localparam logic signed [18:0] OUT_MAX = 19'sd32767;
    localparam logic signed [18:0] OUT_MIN = -19'sd32768;

    // Clamp a 19-bit value into the signed 16-bit output range
    function automatic logic signed [15:0] f_sat16(input logic signed [18:0] v);
        logic signed [15:0] r;
        if (v > OUT_MAX) begin
            r = 16'sh7fff;
        end else if (v < OUT_MIN) begin
            r = -16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // Floor a Q28 sum down to Q14 and clamp it
    function automatic logic signed [15:0] f_q14(input logic signed [32:0] v);
        return f_sat16(v[32:14]);
    endfunction

endpackage

// File: rtl/erm_sincos.sv
// Five-stage quintic polynomial sine unit, Q12 argument in, Q14 value out.
module erm_sincos (
    input  logic               i_clk,
    input  logic [4:0]         i_en,
    input  logic signed [15:0] i_t,
    output logic signed [15:0] o_s
);

    // Stage a: square
    logic signed [15:0] r_t_a;
    logic signed [17:0] r_t2_a;
    logic signed [31:0] n_sq;

    // Stage b: cube and linear term
    logic signed [17:0] r_t2_b;
    logic signed [18:0] r_t3_b;
    logic signed [35:0] r_p1_b;
    logic signed [33:0] n_cu;
    logic signed [35:0] n_p1;

    // Stage c: fifth power and cubic term
    logic signed [21:0] r_t5_c;
    logic signed [35:0] r_p3_c;
    logic signed [35:0] r_p1_c;
    logic signed [36:0] n_qu;
    logic signed [35:0] n_p3;

    // Stage d: quintic term and partial sum
    logic signed [35:0] r_p5_d;
    logic signed [36:0] r_d13_d;
    logic signed [35:0] n_p5;
    logic signed [36:0] n_d13;

    // Stage e: final sum and scale
    logic signed [15:0] r_s_e;
    logic signed [37:0] n_acc;

    // Squared argument is nonnegative and below 2^17 after the shift
    assign n_sq = i_t * i_t;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_t_a  <= i_t;
            r_t2_a <= n_sq[29:12];
        end
    end

    // Cube stays within 19 signed bits for any reduced argument
    assign n_cu = r_t2_a * r_t_a;
    assign n_p1 = 36'(erm_pkg::C1_Q20) * r_t_a;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_t2_b <= r_t2_a;
            r_t3_b <= n_cu[30:12];
            r_p1_b <= n_p1;
        end
    end

    // Fifth power stays within 22 signed bits
    assign n_qu = r_t3_b * r_t2_b;
    assign n_p3 = 36'(erm_pkg::C3_Q20) * 36'(r_t3_b);

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_t5_c <= n_qu[33:12];
            r_p3_c <= n_p3;
            r_p1_c <= r_p1_b;
        end
    end

    assign n_p5  = 36'(erm_pkg::C5_Q20) * 36'(r_t5_c);
    assign n_d13 = 37'(r_p1_c) - 37'(r_p3_c);

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_p5_d  <= n_p5;
            r_d13_d <= n_d13;
        end
    end

    // The polynomial stays near +-1.004 over the reduced range, so Q14 fits 16 bits
    assign n_acc = 38'(r_d13_d) + 38'(r_p5_d);

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_s_e <= n_acc[33:18];
        end
    end

    assign o_s = r_s_e;

endmodule

// File: rtl/erm_matrix.sv
// Three-stage product and sum network that forms the nine matrix entries.
module erm_matrix (
    input  logic               i_clk,
    input  logic [2:0]         i_en,
    input  logic signed [15:0] i_sx,
    input  logic signed [15:0] i_cx,
    input  logic signed [15:0] i_sy,
    input  logic signed [15:0] i_cy,
    input  logic signed [15:0] i_sz,
    input  logic signed [15:0] i_cz,
    output logic signed [15:0] o_m00,
    output logic signed [15:0] o_m01,
    output logic signed [15:0] o_m02,
    output logic signed [15:0] o_m10,
    output logic signed [15:0] o_m11,
    output logic signed [15:0] o_m12,
    output logic signed [15:0] o_m20,
    output logic signed [15:0] o_m21,
    output logic signed [15:0] o_m22
);

    // Stage 1: shared x-y products
    logic signed [15:0] r_sx1, r_cx1, r_sy1, r_cy1, r_sz1, r_cz1;
    logic signed [15:0] r_sxsy1, r_cxsy1;
    logic signed [31:0] n_sxsy, n_cxsy;

    // Stage 2: all entry products
    logic signed [31:0] r_cycz, r_czsxsy, r_cxsz, r_czcxsy, r_sxsz, r_cysz;
    logic signed [31:0] r_szsxsy, r_cxcz, r_szcxsy, r_sxcz, r_sxcy, r_cxcy;
    logic signed [15:0] r_sy2;

    // Stage 3: output words
    logic signed [15:0] r_m00, r_m01, r_m02, r_m10, r_m11, r_m12;
    logic signed [15:0] r_m20, r_m21, r_m22;
    logic signed [18:0] n_negsy;

    assign n_sxsy = i_sx * i_sy;
    assign n_cxsy = i_cx * i_sy;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_sx1   <= i_sx;
            r_cx1   <= i_cx;
            r_sy1   <= i_sy;
            r_cy1   <= i_cy;
            r_sz1   <= i_sz;
            r_cz1   <= i_cz;
            r_sxsy1 <= n_sxsy[29:14];
            r_cxsy1 <= n_cxsy[29:14];
        end
    end

    // Form every product the entries need
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_cycz   <= r_cy1 * r_cz1;
            r_czsxsy <= r_cz1 * r_sxsy1;
            r_cxsz   <= r_cx1 * r_sz1;
            r_czcxsy <= r_cz1 * r_cxsy1;
            r_sxsz   <= r_sx1 * r_sz1;
            r_cysz   <= r_cy1 * r_sz1;
            r_szsxsy <= r_sz1 * r_sxsy1;
            r_cxcz   <= r_cx1 * r_cz1;
            r_szcxsy <= r_sz1 * r_cxsy1;
            r_sxcz   <= r_sx1 * r_cz1;
            r_sxcy   <= r_sx1 * r_cy1;
            r_cxcy   <= r_cx1 * r_cy1;
            r_sy2    <= r_sy1;
        end
    end

    assign n_negsy = -19'(r_sy2);

    // Sum pairs exactly, floor once, clamp; m20 is the clamped negation of sy
    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_m00 <= erm_pkg::f_q14(33'(r_cycz));
            r_m01 <= erm_pkg::f_q14(33'(r_czsxsy) - 33'(r_cxsz));
            r_m02 <= erm_pkg::f_q14(33'(r_czcxsy) + 33'(r_sxsz));
            r_m10 <= erm_pkg::f_q14(33'(r_cysz));
            r_m11 <= erm_pkg::f_q14(33'(r_szsxsy) + 33'(r_cxcz));
            r_m12 <= erm_pkg::f_q14(33'(r_szcxsy) - 33'(r_sxcz));
            r_m20 <= erm_pkg::f_sat16(n_negsy);
            r_m21 <= erm_pkg::f_q14(33'(r_sxcy));
            r_m22 <= erm_pkg::f_q14(33'(r_cxcy));
        end
    end

    assign o_m00 = r_m00;
    assign o_m01 = r_m01;
    assign o_m02 = r_m02;
    assign o_m10 = r_m10;
    assign o_m11 = r_m11;
    assign o_m12 = r_m12;
    assign o_m20 = r_m20;
    assign o_m21 = r_m21;
    assign o_m22 = r_m22;

endmodule

// File: rtl/euler_rotation_matrix.sv
// Top level: angle reduction stage, six sine/cosine units, matrix network, stall control.
//
// Takes one angle triple (Q3.12 radians) per cycle while o_stall is low and returns
// Rz*Ry*Rx in Q1.14. The path is a nine-stage pipeline: one stage reduces the six
// arguments, five stages evaluate the quintic sine polynomial, and three stages form
// and sum the matrix products, the last being the output register. Every stage
// carries a valid bit and holds its word only while the stage after it is full and
// held, so a stalled output lets earlier stages keep filling their empty slots;
// o_stall rises only when every stage is full and i_stall is high.
module euler_rotation_matrix (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_angle_x,
    input  logic signed [15:0] i_angle_y,
    input  logic signed [15:0] i_angle_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_m00,
    output logic signed [15:0] o_m01,
    output logic signed [15:0] o_m02,
    output logic signed [15:0] o_m10,
    output logic signed [15:0] o_m11,
    output logic signed [15:0] o_m12,
    output logic signed [15:0] o_m20,
    output logic signed [15:0] o_m21,
    output logic signed [15:0] o_m22
);

    localparam int STAGES = 9;

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] w_adv;

    logic signed [15:0] r_tsx, r_tcx, r_tsy, r_tcy, r_tsz, r_tcz;
    logic signed [15:0] w_sx, w_cx, w_sy, w_cy, w_sz, w_cz;

    // Reduce once by 2*pi when outside [-pi, pi]; result fits 16 signed bits
    function automatic logic signed [15:0] f_reduce(input logic signed [16:0] t);
        logic signed [16:0] r;
        if (t > erm_pkg::PI_Q12) begin
            r = t - erm_pkg::TWO_PI_Q12;
        end else if (t < -erm_pkg::PI_Q12) begin
            r = t + erm_pkg::TWO_PI_Q12;
        end else begin
            r = t;
        end
        return r[15:0];
    endfunction

    // A stage advances when it is empty or the stage after it advances
    always_comb begin
        w_adv[STAGES-1] = !r_vld[STAGES-1] || !i_stall;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign o_stall = !w_adv[0];
    assign o_valid = r_vld[STAGES-1];

    // Move valid bits along with their words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Reduce sine and cosine arguments
    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_tsx <= f_reduce(17'(i_angle_x));
            r_tcx <= f_reduce(17'(i_angle_x) + erm_pkg::HALF_PI_Q12);
            r_tsy <= f_reduce(17'(i_angle_y));
            r_tcy <= f_reduce(17'(i_angle_y) + erm_pkg::HALF_PI_Q12);
            r_tsz <= f_reduce(17'(i_angle_z));
            r_tcz <= f_reduce(17'(i_angle_z) + erm_pkg::HALF_PI_Q12);
        end
    end

    erm_sincos u_sx (.i_clk(i_clk), .i_en(w_adv[5:1]), .i_t(r_tsx), .o_s(w_sx));
    erm_sincos u_cx (.i_clk(i_clk), .i_en(w_adv[5:1]), .i_t(r_tcx), .o_s(w_cx));
    erm_sincos u_sy (.i_clk(i_clk), .i_en(w_adv[5:1]), .i_t(r_tsy), .o_s(w_sy));
    erm_sincos u_cy (.i_clk(i_clk), .i_en(w_adv[5:1]), .i_t(r_tcy), .o_s(w_cy));
    erm_sincos u_sz (.i_clk(i_clk), .i_en(w_adv[5:1]), .i_t(r_tsz), .o_s(w_sz));
    erm_sincos u_cz (.i_clk(i_clk), .i_en(w_adv[5:1]), .i_t(r_tcz), .o_s(w_cz));

    erm_matrix u_matrix (
        .i_clk (i_clk),
        .i_en  (w_adv[8:6]),
        .i_sx  (w_sx),
        .i_cx  (w_cx),
        .i_sy  (w_sy),
        .i_cy  (w_cy),
        .i_sz  (w_sz),
        .i_cz  (w_cz),
        .o_m00 (o_m00),
        .o_m01 (o_m01),
        .o_m02 (o_m02),
        .o_m10 (o_m10),
        .o_m11 (o_m11),
        .o_m12 (o_m12),
        .o_m20 (o_m20),
        .o_m21 (o_m21),
        .o_m22 (o_m22)
    );

endmodule

// File: dv/euler_rotation_matrix_tb.sv
// Self-checking testbench: corner and random angle triples against a bit-exact rotation matrix predictor.
`timescale 1ns / 100ps

module euler_rotation_matrix_tb;

    // Angle constants, Q12 radians
    localparam longint ANG_PI      = 12868;
    localparam longint ANG_TWO_PI  = 25736;
    localparam longint ANG_HALF_PI = 6434;
    // Quintic sine coefficients, Q20
    localparam longint SIN_C1 = 1035848;
    localparam longint SIN_C3 = 162813;
    localparam longint SIN_C5 = 5917;

    localparam int N_CORNER   = 19;
    localparam int N_RANDOM   = 500;
    localparam int TAIL_WAIT  = 24;
    localparam int CYCLE_LIMIT = 200000;

    // One angle triple plus the idle cycles that follow it on the input side
    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic [2:0]         gap;
    } angle_word_t;

    // Nine matrix entries, index 3*row + column
    typedef logic [8:0][15:0] matrix_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [15:0] i_angle_x = '0;
    logic signed [15:0] i_angle_y = '0;
    logic signed [15:0] i_angle_z = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [15:0] o_m00, o_m01, o_m02;
    logic signed [15:0] o_m10, o_m11, o_m12;
    logic signed [15:0] o_m20, o_m21, o_m22;

    angle_word_t angle_q[$];
    matrix_t     matrix_q[$];
    int          n_errors = 0;
    int          n_results = 0;
    int          cycle_cnt = 0;
    logic [2:0]  idle_cnt = '0;
    logic [2:0]  hold_cnt = '0;

    euler_rotation_matrix dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_angle_x (i_angle_x),
        .i_angle_y (i_angle_y),
        .i_angle_z (i_angle_z),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_m00     (o_m00),
        .o_m01     (o_m01),
        .o_m02     (o_m02),
        .o_m10     (o_m10),
        .o_m11     (o_m11),
        .o_m12     (o_m12),
        .o_m20     (o_m20),
        .o_m21     (o_m21),
        .o_m22     (o_m22)
    );

    // Run the 4 ns clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Wrap once by 2*pi; the rounded pi itself stays put
    function automatic longint wrap_angle(input longint t);
        if (t > ANG_PI) begin
            return t - ANG_TWO_PI;
        end
        if (t < -ANG_PI) begin
            return t + ANG_TWO_PI;
        end
        return t;
    endfunction

    // Quintic sine: Q12 argument in, unsaturated Q14 out, every shift floors
    function automatic longint poly_sine(input longint t);
        longint t2, t3, t5;
        t2 = (t * t) >>> 12;
        t3 = (t2 * t) >>> 12;
        t5 = (t3 * t2) >>> 12;
        return (SIN_C1 * t - SIN_C3 * t3 + SIN_C5 * t5) >>> 18;
    endfunction

    // Clamp to the Q1.14 output range
    function automatic logic [15:0] to_q14(input longint v);
        if (v > 32767) begin
            return 16'h7fff;
        end
        if (v < -32768) begin
            return 16'h8000;
        end
        return 16'(v);
    endfunction

    // Form Rz*Ry*Rx; two-term entries sum exactly before the single floor
    function automatic matrix_t rotation_from_angles(input logic signed [15:0] ax,
                                                     input logic signed [15:0] ay,
                                                     input logic signed [15:0] az);
        longint  sx, cx, sy, cy, sz, cz, sxsy, cxsy;
        matrix_t r;
        sx = poly_sine(wrap_angle(longint'(ax)));
        cx = poly_sine(wrap_angle(longint'(ax) + ANG_HALF_PI));
        sy = poly_sine(wrap_angle(longint'(ay)));
        cy = poly_sine(wrap_angle(longint'(ay) + ANG_HALF_PI));
        sz = poly_sine(wrap_angle(longint'(az)));
        cz = poly_sine(wrap_angle(longint'(az) + ANG_HALF_PI));
        sxsy = (sx * sy) >>> 14;
        cxsy = (cx * sy) >>> 14;
        r[0] = to_q14((cy * cz) >>> 14);
        r[1] = to_q14((cz * sxsy - cx * sz) >>> 14);
        r[2] = to_q14((cz * cxsy + sx * sz) >>> 14);
        r[3] = to_q14((cy * sz) >>> 14);
        r[4] = to_q14((sz * sxsy + cx * cz) >>> 14);
        r[5] = to_q14((sz * cxsy - sx * cz) >>> 14);
        r[6] = to_q14(-sy);
        r[7] = to_q14((sx * cy) >>> 14);
        r[8] = to_q14((cx * cy) >>> 14);
        return r;
    endfunction

    // Corner angles: range ends, both sides of +-pi, the cosine wrap points, 3*pi region, +-2*pi, bit patterns
    function automatic logic signed [15:0] corner_angle(input int k);
        case (k)
            0:       return 16'sd0;
            1:       return 16'sd1;
            2:       return -16'sd1;
            3:       return 16'sd32767;
            4:       return -16'sd32768;
            5:       return 16'sd12868;
            6:       return 16'sd12869;
            7:       return -16'sd12868;
            8:       return -16'sd12869;
            9:       return 16'sd6434;
            10:      return 16'sd6435;
            11:      return -16'sd19302;
            12:      return -16'sd19303;
            13:      return 16'sd32170;
            14:      return 16'sd32171;
            15:      return 16'sd25736;
            16:      return -16'sd25736;
            17:      return 16'sh5555;
            default: return 16'shaaaa;
        endcase
    endfunction

    // Draw an angle: full range, the principal range, near wrap points, or near the ends
    function automatic logic signed [15:0] rand_angle();
        int pick;
        int base;
        pick = int'($urandom_range(0, 99));
        if (pick < 45) begin
            return 16'($urandom);
        end
        if (pick < 75) begin
            return 16'(int'($urandom_range(0, 25736)) - 12868);
        end
        if (pick < 92) begin
            case ($urandom_range(0, 4))
                0:       base = 12868;
                1:       base = -12868;
                2:       base = 6434;
                3:       base = -19302;
                default: base = 32170;
            endcase
            return 16'(base + int'($urandom_range(0, 16)) - 8);
        end
        if ($urandom_range(0, 1) == 1) begin
            return 16'(32256 + int'($urandom_range(0, 511)));
        end
        return 16'(-32768 + int'($urandom_range(0, 511)));
    endfunction

    task automatic report(input string what);
        $display("ERROR @%0t: %s", $time, what);
        n_errors++;
    endtask

    // Fill the word queue, release reset, then drain and judge
    initial begin : stimulus
        angle_word_t w;
        int i;
        for (i = 0; i < N_CORNER; i++) begin
            w.ax  = corner_angle(i);
            w.ay  = corner_angle((i + 5) % N_CORNER);
            w.az  = corner_angle((i + 11) % N_CORNER);
            w.gap = 3'($urandom_range(0, 7));
            angle_q.push_back(w);
        end
        for (i = 0; i < N_RANDOM; i++) begin
            w.ax = rand_angle();
            w.ay = rand_angle();
            w.az = rand_angle();
            // Every third stretch of 64 words goes back to back
            w.gap = (((i >> 6) % 3) == 2) ? 3'd0 : 3'($urandom_range(0, 7));
            angle_q.push_back(w);
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Wait until every sent word has come back, then watch for strays
        while (n_results < N_CORNER + N_RANDOM) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (n_errors == 0 && matrix_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Drive angle words; predict each one as it is accepted
    always @(posedge i_clk) begin : drive
        angle_word_t w;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid) begin
                matrix_q.push_back(rotation_from_angles(i_angle_x, i_angle_y, i_angle_z));
            end
            if (idle_cnt != 0) begin
                i_valid  <= 1'b0;
                idle_cnt <= idle_cnt - 3'd1;
            end else if (angle_q.size() != 0) begin
                w = angle_q.pop_front();
                i_valid   <= 1'b1;
                i_angle_x <= w.ax;
                i_angle_y <= w.ay;
                i_angle_z <= w.az;
                idle_cnt  <= w.gap;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Check each accepted matrix word against the oldest prediction, then draw a stall
    always @(posedge i_clk) begin : watch
        matrix_t got, want;
        logic [2:0] hold;
        int k;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_m22, o_m21, o_m20, o_m12, o_m11, o_m10, o_m02, o_m01, o_m00};
            if (matrix_q.size() == 0) begin
                report($sformatf("matrix word %0d with none pending", n_results));
            end else begin
                want = matrix_q.pop_front();
                for (k = 0; k < 9; k++) begin
                    if (got[k] !== want[k]) begin
                        report($sformatf("word %0d m%0d%0d got %0d want %0d", n_results,
                                         k / 3, k % 3, $signed(got[k]), $signed(want[k])));
                    end
                end
            end
            n_results <= n_results + 1;
            // Hold off for a random count, except in every third stretch of 64 words
            hold = (((n_results >> 6) % 3) == 1) ? 3'd0 : 3'($urandom_range(0, 7));
            i_stall  <= (hold != 0);
            hold_cnt <= hold;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 3'd1;
            i_stall  <= (hold_cnt != 3'd1);
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule

// File: euler_rotation_matrix.f
rtl/erm_pkg.sv
rtl/erm_sincos.sv
rtl/erm_matrix.sv
rtl/euler_rotation_matrix.sv
dv/euler_rotation_matrix_tb.sv
